// ===== hw/rtl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

   localparam int WordWidth  = 32;
   localparam int FifoDepth  = 4;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] data;
   } cmd_type;

   localparam logic [1:0] CmdData   = 2'd0;
   localparam logic [1:0] CmdPadEnd = 2'd1;
   localparam logic [1:0] CmdLenHi  = 2'd2;
   localparam logic [1:0] CmdLenLo  = 2'd3;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
`default_nettype none
// SHA-256 over a stream of big-endian 32-bit words (first byte in bits 31:24);
// mark the final word with end_of_message and valid_bytes 0..4. Eight digest
// words follow, index 0 first, and the block restarts from the initial vector.
// A front end pads the final word and appends the bit length into a small
// command queue; the back end adds the remaining padding, fills a 16-word
// window and runs one round per cycle with its single round unit, and takes
// no commands while it compresses a block or sends the digest.
module sha256_stream_hasher
   import sha256_pkg::*;
#(
   parameter int QueueDepth = FifoDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_message_word,
   input  wire logic [2:0]  req_valid_bytes,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   logic    f_valid, f_ready, b_valid, b_ready;
   cmd_type f_cmd, b_cmd;

   sha256_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_message_word,
      .req_valid_bytes, .req_end_of_message,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

   sha256_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd));

   sha256_back u_back (
      .clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_index, .rsp_last_word);
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_front.sv =====
`default_nettype none
module sha256_front
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_message_word,
   input  wire logic [2:0]  req_valid_bytes,
   input  wire logic        req_end_of_message,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);
   // final word issues padded word, then length hi, length lo
   typedef enum logic [2:0] {
      StIdle  = 3'b001,
      StLenHi = 3'b010,
      StLenLo = 3'b100
   } st_type;

   st_type      st_ff, st_in;
   logic [63:0] count_ff, count_in;
   logic [2:0]  vb;
   logic [31:0] mask, padded;

   always_comb begin
      vb = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
      case (vb)
         3'd0:    mask = 32'h0000_0000;
         3'd1:    mask = 32'hff00_0000;
         3'd2:    mask = 32'hffff_0000;
         3'd3:    mask = 32'hffff_ff00;
         default: mask = 32'hffff_ffff;
      endcase
      case (vb)
         3'd0:    padded = 32'h8000_0000;
         3'd1:    padded = (req_message_word & mask) | 32'h0080_0000;
         3'd2:    padded = (req_message_word & mask) | 32'h0000_8000;
         3'd3:    padded = (req_message_word & mask) | 32'h0000_0080;
         default: padded = req_message_word;
      endcase
   end

   always_comb begin
      st_in     = st_ff;
      count_in  = count_ff;
      req_ready = 1'b0;
      cmd_valid = 1'b0;
      cmd       = '{kind: CmdData, data: req_message_word};
      case (st_ff)
         StIdle: begin
            req_ready = cmd_ready;
            cmd_valid = req_valid;
            if (req_end_of_message) begin
               cmd.kind = (vb == 3'd4) ? CmdData : CmdPadEnd;
               cmd.data = padded;
            end
            if (req_valid && cmd_ready) begin
               if (req_end_of_message) begin
                  count_in = count_ff + 64'(vb);
                  st_in    = StLenHi;
               end else begin
                  count_in = count_ff + 64'd4;
               end
            end
         end
         StLenHi: begin
            cmd_valid = 1'b1;
            cmd       = '{kind: CmdLenHi, data: count_ff[60:29]};
            if (cmd_ready) st_in = StLenLo;
         end
         StLenLo: begin
            cmd_valid = 1'b1;
            cmd       = '{kind: CmdLenLo, data: {count_ff[28:0], 3'b000}};
            if (cmd_ready) begin
               st_in    = StIdle;
               count_in = '0;
            end
         end
         default: st_in = StIdle;
      endcase
   end

   // a full final word still needs its 0x80 word: back adds it when LenHi comes without PadEnd
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= StIdle;
         count_ff <= '0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff != StIdle) |-> !req_ready)
      else $error("input taken while emitting length");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == StLenHi && cmd_ready) |=> (st_ff == StLenLo))
      else $error("length words out of order");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == StLenLo && cmd_ready) |=> (count_ff == '0))
      else $error("count not cleared");
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_fifo.sv =====
`default_nettype none
module sha256_fifo
   import sha256_pkg::*;
#(
   parameter int Depth = FifoDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_valid,
   output logic         wr_ready,
   input  wire cmd_type wr_data,
   output logic         rd_valid,
   input  wire logic    rd_ready,
   output cmd_type      rd_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   cmd_type           mem_ff [Depth];
   logic [AW-1:0]     wp_ff, rp_ff;
   logic [AW:0]       cnt_ff;
   logic              push, pop;

   assign wr_ready = (cnt_ff != (AW+1)'(Depth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth))
      else $error("fifo overflow");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("fifo count slip");
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("fifo count slip");
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_back.sv =====
`default_nettype none
module sha256_back
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  wire cmd_type     cmd,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   // Loading: take commands. Round: 64 rounds. Add: fold into hash. Output: 8 digest words.
   typedef enum logic [3:0] {
      StLoad  = 4'b0001,
      StRound = 4'b0010,
      StAdd   = 4'b0100,
      StOut   = 4'b1000
   } st_type;

   st_type      st_ff, st_in;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic [3:0]  fill_ff, fill_in;
   logic [5:0]  rnd_ff;
   logic [2:0]  oidx_ff;
   // pad_ff: a full final word was pushed, 0x80 word still owed
   // zfill_ff: zero-fill until fill==14, then expect length
   logic        pad_ff, zfill_ff, fin_ff;

   logic        push;
   word_type    push_word;
   logic        take;
   logic        owe;
   word_type    wt, s0, s1, t1, t2, wa, wb;

   always_comb begin
      wa = w_ff[4'(rnd_ff - 6'd2)];
      wb = w_ff[4'(rnd_ff - 6'd15)];
      s1 = rotr(wa, 17) ^ rotr(wa, 19) ^ (wa >> 10);
      s0 = rotr(wb, 7) ^ rotr(wb, 18) ^ (wb >> 3);
      wt = (rnd_ff < 6'd16) ? w_ff[rnd_ff[3:0]]
         : s1 + w_ff[4'(rnd_ff - 6'd7)] + s0 + w_ff[rnd_ff[3:0]];
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_const(rnd_ff) + wt;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // in load state: priority owed pad word, then zero fill, then commands
   // full final word: front sends CmdData then LenHi; a LenHi without a
   // preceding PadEnd stays queued while the pad word and zeros go in
   always_comb begin
      push      = 1'b0;
      push_word = cmd.data;
      take      = 1'b0;
      owe       = 1'b0;
      cmd_ready = 1'b0;
      if (st_ff == StLoad) begin
         if (pad_ff) begin
            push      = 1'b1;
            push_word = 32'h8000_0000;
         end else if (zfill_ff && fill_ff != 4'd14) begin
            push      = 1'b1;
            push_word = '0;
         end else if (cmd_valid && cmd.kind == CmdLenHi && !zfill_ff) begin
            owe       = 1'b1;
         end else begin
            cmd_ready = 1'b1;
            take      = cmd_valid;
            push      = cmd_valid;
         end
      end
   end

   assign fill_in = fill_ff + 4'd1;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         StLoad:  if (push && fill_ff == 4'd15) st_in = StRound;
         StRound: if (rnd_ff == 6'd63) st_in = StAdd;
         StAdd:   st_in = fin_ff ? StOut : StLoad;
         StOut:   if (rsp_ready && oidx_ff == 3'd7) st_in = StLoad;
         default: st_in = StLoad;
      endcase
   end

   assign rsp_valid       = (st_ff == StOut);
   assign rsp_digest_word = h_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (push) w_ff[fill_ff] <= push_word;
      if (st_ff == StRound) begin
         w_ff[rnd_ff[3:0]] <= wt;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= StLoad;
         fill_ff  <= '0;
         rnd_ff   <= '0;
         oidx_ff  <= '0;
         pad_ff   <= 1'b0;
         zfill_ff <= 1'b0;
         fin_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         st_ff <= st_in;
         if (push) fill_ff <= fill_in;
         if (push && pad_ff) pad_ff <= 1'b0;
         if (take) begin
            case (cmd.kind)
               CmdPadEnd: zfill_ff <= 1'b1;
               CmdLenHi:  begin
                  pad_ff   <= 1'b0;
                  zfill_ff <= 1'b0;
               end
               CmdLenLo:  fin_ff <= 1'b1;
               default:   ;
            endcase
         end
         if (owe) begin
            pad_ff   <= 1'b1;
            zfill_ff <= 1'b1;
         end
         if (st_ff == StRound) rnd_ff <= rnd_ff + 6'd1;
         if (st_ff == StAdd) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
         if (st_ff == StOut && rsp_ready) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               fin_ff <= 1'b0;
               for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == StRound && rnd_ff == 6'd63) |=> (st_ff == StAdd))
      else $error("round count slip");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (st_ff == StOut && !cmd_ready))
      else $error("load during output");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == StOut) |-> (fill_ff == 4'd0))
      else $error("digest with partial block");
endmodule
`default_nettype wire
